// ===== hw/rtl/rfc_pkg.sv =====
// ----------------------------------------------------------------------------
// rfc_pkg
// shared types and constants for the rectangle fill canvas
// ----------------------------------------------------------------------------
package rfc_pkg;

    localparam int SUM_W = 9;

    localparam logic [1:0] OP_DRAW  = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    localparam logic [23:0] WHITE_PIXEL = 24'hFFFFFF;

    typedef struct packed {
        logic [1:0] operation;
        logic [6:0] left;
        logic [6:0] top;
        logic [7:0] width;
        logic [7:0] height;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_in_word;

    typedef struct packed {
        logic [7:0] pixel_red;
        logic [7:0] pixel_green;
        logic [7:0] pixel_blue;
        logic [7:0] extent_cols;
        logic [7:0] extent_rows;
    } t_out_word;

    typedef struct packed {
        logic start;
        logic full;
    } t_walk_ctl;

    typedef struct packed {
        logic we;
        logic full;
        logic done;
    } t_walk_sts;

endpackage

// ===== hw/rtl/rfc_mem.sv =====
// ----------------------------------------------------------------------------
// rfc_mem
// pixel store, one write port and one registered read port
// ----------------------------------------------------------------------------
module rfc_mem
    import rfc_pkg::*;
#(
    parameter int AW = 14
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [23:0]   i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [23:0]   o_rdata
);

    logic [23:0] r_mem [0:(1 << AW) - 1];
    logic [23:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/rfc_walk.sv =====
// ----------------------------------------------------------------------------
// rfc_walk
// raster walker, one pixel address per cycle over a rectangle or the canvas
// ----------------------------------------------------------------------------
module rfc_walk
    import rfc_pkg::*;
#(
    parameter int CW = 7,
    parameter int EW = 9
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  t_walk_ctl       i_ctl,
    input  logic [EW-1:0]   i_x0,
    input  logic [EW-1:0]   i_y0,
    input  logic [EW-1:0]   i_x1,
    input  logic [EW-1:0]   i_y1,
    output t_walk_sts       o_sts,
    output logic [2*CW-1:0] o_addr
);

    localparam logic [EW-1:0] SPAN = {{(EW-1){1'b0}}, 1'b1} << CW;

    logic          r_active;
    logic          r_done;
    logic          r_full;
    logic [EW-1:0] r_x;
    logic [EW-1:0] r_y;
    logic [EW-1:0] r_x0;
    logic [EW-1:0] r_x1;
    logic [EW-1:0] r_y1;

    logic [EW-1:0] x0;
    logic [EW-1:0] y0;
    logic [EW-1:0] x1;
    logic [EW-1:0] y1;
    logic          empty;
    logic [EW-1:0] n_x;
    logic [EW-1:0] n_y;
    logic          n_done;

    always_comb begin
        x0     = i_ctl.full ? '0 : i_x0;
        y0     = i_ctl.full ? '0 : i_y0;
        x1     = i_ctl.full ? SPAN : i_x1;
        y1     = i_ctl.full ? SPAN : i_y1;
        empty  = (x0 >= x1) || (y0 >= y1);
        n_x    = r_x + 1'b1;
        n_y    = r_y + 1'b1;
        n_done = i_ctl.start ? empty : (r_active && (n_x == r_x1) && (n_y == r_y1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_done   <= 1'b0;
            r_full   <= 1'b0;
        end else begin
            r_done <= n_done;
            if (i_ctl.start) begin
                r_active <= !empty;
                r_full   <= i_ctl.full;
                r_x      <= x0;
                r_y      <= y0;
                r_x0     <= x0;
                r_x1     <= x1;
                r_y1     <= y1;
            end else if (r_active) begin
                if (n_x == r_x1) begin
                    r_x <= r_x0;
                    if (n_y == r_y1) begin
                        r_active <= 1'b0;
                    end else begin
                        r_y <= n_y;
                    end
                end else begin
                    r_x <= n_x;
                end
            end
        end
    end

    assign o_sts.we   = r_active;
    assign o_sts.full = r_full;
    assign o_sts.done = r_done;
    assign o_addr     = {r_y[CW-1:0], r_x[CW-1:0]};

endmodule

// ===== hw/rtl/rectangle_fill_canvas.sv =====
// ----------------------------------------------------------------------------
// rectangle_fill_canvas
// square rgb canvas with rectangle fill, pixel read, clear and drawn extents
//
// channel   direction  ports                      handshake
// command   in         start, busy, i_word        taken when start and !busy
// result    out        o_strobe, o_word           one word per command, 1 cycle
//
// draw: result strobed once the walker reports done over the clipped area, also when it is empty
// read: one registered memory read; clear: a white walk over the full power-of-two square of the canvas
// one pixel written per cycle, set by the single memory write port
// after reset busy stays high for the white fill
// the receiver cannot stall; each result is shown for exactly one cycle
// ----------------------------------------------------------------------------
module rectangle_fill_canvas
    import rfc_pkg::*;
#(
    parameter int CANVAS_SIZE = 128
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    input  t_in_word  i_word,
    output logic      busy,
    output logic      o_strobe,
    output t_out_word o_word
);

    localparam int CW = $clog2(CANVAS_SIZE);
    localparam int EW = (CW + 1 > SUM_W) ? CW + 1 : SUM_W;
    localparam int AW = 2 * CW;
    localparam logic [EW-1:0] SIZE_E = EW'(CANVAS_SIZE);

    typedef enum logic [1:0] {
        S_INIT,
        S_IDLE,
        S_WALK,
        S_READ
    } t_state;

    t_state        r_state;
    t_walk_ctl     r_walk;
    logic [EW-1:0] r_x0;
    logic [EW-1:0] r_y0;
    logic [EW-1:0] r_x1;
    logic [EW-1:0] r_y1;
    logic [23:0]   r_color;
    logic [EW-1:0] r_ext_c;
    logic [EW-1:0] r_ext_r;
    logic          r_in_range;
    logic          r_strobe;
    t_out_word     r_result;

    t_walk_sts     walk_sts;
    logic [AW-1:0] walk_addr;
    logic [23:0]   wdata;
    logic [23:0]   rdata;
    logic          accept;
    logic          known_op;
    logic          n_strobe;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic [EW-1:0] sum_x;
    logic [EW-1:0] sum_y;
    logic [EW-1:0] x1;
    logic [EW-1:0] y1;
    logic          in_range;

    always_comb begin
        accept   = start && (r_state == S_IDLE);
        known_op = (i_word.operation == OP_DRAW) || (i_word.operation == OP_READ) ||
                   (i_word.operation == OP_CLEAR);
        n_strobe = (accept && !known_op) || ((r_state == S_WALK) && walk_sts.done) ||
                   (r_state == S_READ);
        sum_x    = EW'(i_word.left) + EW'(i_word.width);
        sum_y    = EW'(i_word.top) + EW'(i_word.height);
        x1       = (sum_x > SIZE_E) ? SIZE_E : sum_x;
        y1       = (sum_y > SIZE_E) ? SIZE_E : sum_y;
        in_range = (EW'(i_word.left) < SIZE_E) && (EW'(i_word.top) < SIZE_E);
        rd_en    = accept && (i_word.operation == OP_READ);
        rd_addr  = {CW'(i_word.top), CW'(i_word.left)};
        wdata    = walk_sts.full ? WHITE_PIXEL : r_color;
    end

    rfc_walk #(
        .CW (CW),
        .EW (EW)
    ) u_walk (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (r_walk),
        .i_x0    (r_x0),
        .i_y0    (r_y0),
        .i_x1    (r_x1),
        .i_y1    (r_y1),
        .o_sts   (walk_sts),
        .o_addr  (walk_addr)
    );

    rfc_mem #(
        .AW (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (walk_sts.we),
        .i_waddr (walk_addr),
        .i_wdata (wdata),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_INIT;
            r_walk     <= '{start: 1'b1, full: 1'b1};
            r_ext_c    <= '0;
            r_ext_r    <= '0;
            r_strobe   <= 1'b0;
        end else begin
            r_walk.start <= accept && ((i_word.operation == OP_DRAW) ||
                                       (i_word.operation == OP_CLEAR));
            r_strobe     <= n_strobe;
            unique case (r_state)
                S_INIT: begin
                    if (walk_sts.done) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (accept) begin
                        unique case (i_word.operation)
                            OP_DRAW: begin
                                r_x0        <= EW'(i_word.left);
                                r_y0        <= EW'(i_word.top);
                                r_x1        <= x1;
                                r_y1        <= y1;
                                r_color     <= {i_word.red, i_word.green, i_word.blue};
                                r_walk.full <= 1'b0;
                                if (x1 > r_ext_c) begin
                                    r_ext_c <= x1;
                                end
                                if (y1 > r_ext_r) begin
                                    r_ext_r <= y1;
                                end
                                r_state <= S_WALK;
                            end
                            OP_READ: begin
                                r_in_range <= in_range;
                                r_state    <= S_READ;
                            end
                            OP_CLEAR: begin
                                r_walk.full <= 1'b1;
                                r_ext_c     <= '0;
                                r_ext_r     <= '0;
                                r_state     <= S_WALK;
                            end
                            default: begin
                                r_result <= '{pixel_red: 8'd0, pixel_green: 8'd0,
                                              pixel_blue: 8'd0,
                                              extent_cols: r_ext_c[7:0],
                                              extent_rows: r_ext_r[7:0]};
                            end
                        endcase
                    end
                end
                S_WALK: begin
                    if (walk_sts.done) begin
                        r_state  <= S_IDLE;
                        r_result <= '{pixel_red: 8'd0, pixel_green: 8'd0,
                                      pixel_blue: 8'd0,
                                      extent_cols: r_ext_c[7:0],
                                      extent_rows: r_ext_r[7:0]};
                    end
                end
                S_READ: begin
                    r_state  <= S_IDLE;
                    r_result <= '{pixel_red: r_in_range ? rdata[23:16] : 8'd0,
                                  pixel_green: r_in_range ? rdata[15:8] : 8'd0,
                                  pixel_blue: r_in_range ? rdata[7:0] : 8'd0,
                                  extent_cols: r_ext_c[7:0],
                                  extent_rows: r_ext_r[7:0]};
                end
            endcase
        end
    end

    assign busy     = (r_state != S_IDLE);
    assign o_strobe = r_strobe;
    assign o_word   = r_result;

endmodule

// ===== verif/rectangle_fill_canvas_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rectangle_fill_canvas_tb
// self-checking bench for the rectangle fill canvas
//
// a queue of command words, directed first and then random, feeds a driver
// that raises start at the falling edge and holds it until the word is taken.
// every taken word runs through a behavioral canvas (pixel store and extents)
// whose answer is queued, and each strobed result word is compared field by
// field against the oldest queued answer. gaps between commands are random.
// ----------------------------------------------------------------------------
module rectangle_fill_canvas_tb;
    import rfc_pkg::*;

    localparam int CANVAS_SIZE   = 128;
    localparam int CANVAS_PIXELS = CANVAS_SIZE * CANVAS_SIZE;
    localparam int STALL_LIMIT   = 100000;
    localparam int DRAIN_CYCLES  = 8;
    localparam int RANDOM_ITEMS  = 70;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      start = 1'b0;
    t_in_word  i_word = '0;
    logic      busy;
    logic      o_strobe;
    t_out_word o_word;

    logic [23:0] canvas_model [CANVAS_PIXELS];
    int          col_extent;
    int          row_extent;

    t_in_word    cmd_queue [$];
    t_out_word   expected_words [$];
    int          cmd_total = 0;
    int          cmd_taken = 0;
    int          err_cnt = 0;
    int          stall_cycles = 0;
    logic        word_taken = 1'b0;
    int          idle_left = 0;
    int          burst_left = 0;

    rectangle_fill_canvas #(
        .CANVAS_SIZE(CANVAS_SIZE)
    ) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_word  (i_word),
        .busy    (busy),
        .o_strobe(o_strobe),
        .o_word  (o_word)
    );

    always #2 i_clk = ~i_clk;

    function automatic t_out_word canvas_response(input t_in_word cmd);
        t_out_word   rsp;
        logic [23:0] pix;
        int          x_end;
        int          y_end;
        int          x;
        int          y;
        rsp = '0;
        pix = '0;
        case (cmd.operation)
            OP_DRAW: begin
                x_end = int'(cmd.left) + int'(cmd.width);
                y_end = int'(cmd.top) + int'(cmd.height);
                if (x_end > CANVAS_SIZE) x_end = CANVAS_SIZE;
                if (y_end > CANVAS_SIZE) y_end = CANVAS_SIZE;
                for (y = int'(cmd.top); y < y_end; y++) begin
                    for (x = int'(cmd.left); x < x_end; x++) begin
                        canvas_model[y * CANVAS_SIZE + x] = {cmd.red, cmd.green, cmd.blue};
                    end
                end
                if (x_end > col_extent) col_extent = x_end;
                if (y_end > row_extent) row_extent = y_end;
            end
            OP_READ: begin
                pix = canvas_model[int'(cmd.top) * CANVAS_SIZE + int'(cmd.left)];
            end
            OP_CLEAR: begin
                for (x = 0; x < CANVAS_PIXELS; x++) canvas_model[x] = WHITE_PIXEL;
                col_extent = 0;
                row_extent = 0;
            end
            default: begin
            end
        endcase
        rsp.pixel_red   = pix[23:16];
        rsp.pixel_green = pix[15:8];
        rsp.pixel_blue  = pix[7:0];
        rsp.extent_cols = col_extent[7:0];
        rsp.extent_rows = row_extent[7:0];
        return rsp;
    endfunction

    function automatic t_in_word make_cmd(input logic [1:0] op, input int l, input int t,
                                          input int w, input int h, input logic [23:0] rgb);
        t_in_word cmd;
        cmd.operation = op;
        cmd.left      = l[6:0];
        cmd.top       = t[6:0];
        cmd.width     = w[7:0];
        cmd.height    = h[7:0];
        cmd.red       = rgb[23:16];
        cmd.green     = rgb[15:8];
        cmd.blue      = rgb[7:0];
        return cmd;
    endfunction

    task automatic add_cmd(input logic [1:0] op, input int l, input int t,
                           input int w, input int h, input logic [23:0] rgb);
        cmd_queue.push_back(make_cmd(op, l, t, w, h, rgb));
        cmd_total++;
    endtask

    function automatic int pick_idle();
        int r;
        if (burst_left > 0) begin
            burst_left--;
            return 0;
        end
        if ($urandom_range(0, 19) == 0) begin
            burst_left = $urandom_range(5, 15);
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 40) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 20);
        return $urandom_range(50, 300);
    endfunction

    task automatic check_field(input string name, input logic [7:0] exp_v,
                               input logic [7:0] act_v);
        if (act_v !== exp_v) begin
            $error("%s mismatch: expected %0d, actual %0d", name, exp_v, act_v);
            err_cnt++;
        end
    endtask

    // driver: inputs change on the falling edge
    always @(negedge i_clk) begin
        t_in_word next_cmd;
        if (i_rst_n && (!start || word_taken)) begin
            if (idle_left > 0) begin
                idle_left--;
                start <= 1'b0;
            end else if (cmd_queue.size() != 0) begin
                next_cmd = cmd_queue.pop_front();
                i_word <= next_cmd;
                start  <= 1'b1;
                idle_left = pick_idle();
            end else begin
                start <= 1'b0;
            end
        end
    end

    // monitor: sample on the rising edge
    always @(posedge i_clk) begin
        t_out_word exp_w;
        word_taken <= i_rst_n && start && !busy;
        if (i_rst_n) begin
            if (start && !busy) begin
                expected_words.push_back(canvas_response(i_word));
                cmd_taken++;
            end
            if (o_strobe) begin
                if (expected_words.size() == 0) begin
                    $error("result word with nothing expected");
                    err_cnt++;
                end else begin
                    exp_w = expected_words.pop_front();
                    check_field("pixel_red", exp_w.pixel_red, o_word.pixel_red);
                    check_field("pixel_green", exp_w.pixel_green, o_word.pixel_green);
                    check_field("pixel_blue", exp_w.pixel_blue, o_word.pixel_blue);
                    check_field("extent_cols", exp_w.extent_cols, o_word.extent_cols);
                    check_field("extent_rows", exp_w.extent_rows, o_word.extent_rows);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((start && !busy) || o_strobe) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        int i;
        int n;
        int r;
        int l;
        int t;
        int w;
        int h;
        int last_l;
        int last_t;
        int last_w;
        int last_h;

        for (i = 0; i < CANVAS_PIXELS; i++) canvas_model[i] = WHITE_PIXEL;
        col_extent = 0;
        row_extent = 0;

        // white after reset, full fill, clipping, empty rectangles, unused code
        add_cmd(OP_READ, 0, 0, 0, 0, 24'h000000);
        add_cmd(OP_READ, 127, 127, 255, 255, 24'hFFFFFF);
        add_cmd(OP_DRAW, 0, 0, 128, 128, 24'h000000);
        add_cmd(OP_READ, 127, 127, 0, 0, 24'h000000);
        add_cmd(OP_DRAW, 120, 120, 255, 255, 24'hA5C35A);
        add_cmd(OP_READ, 127, 127, 0, 0, 24'h000000);
        add_cmd(OP_READ, 119, 119, 0, 0, 24'h000000);
        add_cmd(OP_CLEAR, 127, 127, 255, 255, 24'hFFFFFF);
        add_cmd(OP_READ, 5, 5, 0, 0, 24'h000000);
        add_cmd(OP_DRAW, 50, 60, 0, 0, 24'h123456);
        add_cmd(OP_READ, 50, 60, 0, 0, 24'h000000);
        add_cmd(OP_DRAW, 3, 4, 5, 0, 24'h654321);
        add_cmd(OP_READ, 3, 4, 0, 0, 24'h000000);
        add_cmd(OP_DRAW, 100, 2, 10, 3, 24'hFF00AA);
        add_cmd(OP_READ, 109, 4, 0, 0, 24'h000000);
        add_cmd(OP_READ, 110, 4, 0, 0, 24'h000000);
        add_cmd(OP_READ, 100, 2, 0, 0, 24'h000000);
        add_cmd(OP_UNUSED, 100, 2, 255, 255, 24'h00FF00);
        add_cmd(OP_READ, 100, 2, 0, 0, 24'h000000);
        add_cmd(OP_DRAW, 127, 127, 1, 1, 24'h00FF00);
        add_cmd(OP_READ, 127, 127, 0, 0, 24'h000000);
        add_cmd(OP_DRAW, 0, 0, 1, 1, 24'hFFFFFF);
        add_cmd(OP_READ, 0, 0, 0, 0, 24'h000000);

        last_l = 100;
        last_t = 2;
        last_w = 10;
        last_h = 3;
        n = 0;
        while (n < RANDOM_ITEMS) begin
            r = $urandom_range(0, 99);
            if (r < 45) begin
                l = $urandom_range(0, 127);
                t = $urandom_range(0, 127);
                if ($urandom_range(0, 99) < 85) begin
                    w = $urandom_range(0, 24);
                    h = $urandom_range(0, 24);
                end else begin
                    w = $urandom_range(0, 255);
                    h = $urandom_range(0, 255);
                end
                add_cmd(OP_DRAW, l, t, w, h, 24'($urandom()));
                last_l = l;
                last_t = t;
                last_w = w;
                last_h = h;
                n++;
            end else if (r < 88) begin
                if ($urandom_range(0, 99) < 60) begin
                    l = last_l + $urandom_range(0, last_w);
                    t = last_t + $urandom_range(0, last_h);
                    if (l > CANVAS_SIZE - 1) l = CANVAS_SIZE - 1;
                    if (t > CANVAS_SIZE - 1) t = CANVAS_SIZE - 1;
                end else begin
                    l = $urandom_range(0, 127);
                    t = $urandom_range(0, 127);
                end
                add_cmd(OP_READ, l, t, $urandom_range(0, 255), $urandom_range(0, 255),
                        24'($urandom()));
                n++;
            end else if (r < 91) begin
                add_cmd(OP_CLEAR, $urandom_range(0, 127), $urandom_range(0, 127),
                        $urandom_range(0, 255), $urandom_range(0, 255), 24'($urandom()));
                n++;
            end else begin
                add_cmd(OP_UNUSED, $urandom_range(0, 127), $urandom_range(0, 127),
                        $urandom_range(0, 255), $urandom_range(0, 255), 24'($urandom()));
            end
        end

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (cmd_taken < cmd_total || expected_words.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (err_cnt == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/rfc_pkg.sv
hw/rtl/rfc_mem.sv
hw/rtl/rfc_walk.sv
hw/rtl/rectangle_fill_canvas.sv
verif/rectangle_fill_canvas_tb.sv
